// ===== rtl/lpht_pkg.sv =====
package lpht_pkg;

    localparam int KEY_W  = 31;
    localparam int PAY_W  = 32;
    localparam int CFG_W  = 11;
    localparam int REQ_W  = 2;
    localparam int STAT_W = 3;

    localparam logic [CFG_W-1:0] CFG_RESET = 11'd1024;

    localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
    localparam logic [REQ_W-1:0] REQ_SEARCH = 2'd1;
    localparam logic [REQ_W-1:0] REQ_DELETE = 2'd2;

    localparam logic [STAT_W-1:0] STAT_INSERTED  = 3'd0;
    localparam logic [STAT_W-1:0] STAT_FULL      = 3'd1;
    localparam logic [STAT_W-1:0] STAT_FOUND     = 3'd2;
    localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 3'd3;
    localparam logic [STAT_W-1:0] STAT_DELETED   = 3'd4;

    typedef struct packed {
        logic [REQ_W-1:0] req_type;
        logic [KEY_W-1:0] key;
        logic [PAY_W-1:0] payload;
    } req_t;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [KEY_W-1:0]  found_key;
        logic [PAY_W-1:0]  found_payload;
    } resp_t;

    typedef struct packed {
        logic             occupied;
        logic [KEY_W-1:0] key;
        logic [PAY_W-1:0] payload;
    } slot_t;

    localparam int SLOT_W = $bits(slot_t);

endpackage

// ===== rtl/lpht_mod.sv =====
module lpht_mod
    import lpht_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [KEY_W-1:0] dividend,
    input  logic [CFG_W-1:0] divisor,
    output logic             done,
    output logic [CFG_W-1:0] remainder
);

    localparam int CNT_W = $clog2(KEY_W);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [KEY_W-1:0] dvd_reg, dvd_next;
    logic [CFG_W-1:0] dvs_reg, dvs_next;
    logic [CFG_W-1:0] rem_reg, rem_next;
    logic [CFG_W:0]   trial;
    logic [CFG_W:0]   diff;

    // one restoring step per cycle, dividend msb first
    assign trial = {rem_reg, dvd_reg[KEY_W-1]};
    assign diff  = trial - {1'b0, dvs_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        dvs_next  = dvs_reg;
        rem_next  = rem_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(KEY_W - 1);
            dvd_next  = dividend;
            dvs_next  = divisor;
            rem_next  = '0;
        end else if (busy_reg) begin
            dvd_next = {dvd_reg[KEY_W-2:0], 1'b0};
            if (trial >= {1'b0, dvs_reg}) begin
                rem_next = diff[CFG_W-1:0];
            end else begin
                rem_next = trial[CFG_W-1:0];
            end
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        cnt_reg <= cnt_next;
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
        rem_reg <= rem_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

// ===== rtl/lpht_mem.sv =====
module lpht_mem
    import lpht_pkg::*;
#(
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = 10
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  slot_t             wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output slot_t             rd_data
);

    slot_t mem [DEPTH];
    slot_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/linear_probe_hash_table_unit.sv =====
// channel   ports                          moves
// -------   -----------------------------  -----------------------------------
// request   s_valid s_ready s_data         req_type, key, payload
// response  m_valid m_ready m_data         status, found_key, found_payload
// config    cfg_valid cfg_ready cfg_data   table_size, always ready
//
// after reset a clearing pass runs over all TABLE_DEPTH slots, one per cycle,
// before the first request transaction is taken
// full insert or unknown request: goes from accept straight to the result, no divide
// other requests: a restoring divide for the key remainder, then one slot read per cycle;
// the search ends when a slot decides or when the last slot within the size is checked
// one request in flight; the response sits in an output register, and a
// stalled m_ready holds the next result back only when that register is full
module linear_probe_hash_table_unit
    import lpht_pkg::*;
#(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  req_t             s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output resp_t            m_data,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [CFG_W-1:0] cfg_data
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);

    typedef enum logic [4:0] {
        ST_CLEAR = 5'b00001,
        ST_IDLE  = 5'b00010,
        ST_DIV   = 5'b00100,
        ST_PROBE = 5'b01000,
        ST_FIN   = 5'b10000
    } state_t;

    state_t           state_reg, state_next;
    logic [IDX_W-1:0] clr_reg, clr_next;
    logic [CFG_W-1:0] table_size_reg, table_size_next;
    logic [CFG_W-1:0] cnt_reg, cnt_next;
    logic [REQ_W-1:0] req_reg, req_next;
    logic [KEY_W-1:0] key_reg, key_next;
    logic [PAY_W-1:0] pay_reg, pay_next;
    logic [CFG_W-1:0] size_reg, size_next;
    logic [CFG_W-1:0] idx_reg, idx_next;
    logic [CFG_W-1:0] iss_reg, iss_next;
    logic             chk_vld_reg, chk_vld_next;
    logic             chk_last_reg, chk_last_next;
    logic [CFG_W-1:0] chk_idx_reg, chk_idx_next;
    logic             hit_reg, hit_next;
    logic [CFG_W-1:0] hit_idx_reg, hit_idx_next;
    resp_t            res_reg, res_next;
    resp_t            out_reg, out_next;
    logic             m_valid_reg, m_valid_next;

    logic [CFG_W-1:0] size_use;
    logic [CFG_W-1:0] size_last;
    logic             div_start;
    logic             div_done;
    logic [CFG_W-1:0] div_rem;
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    slot_t            mem_wdata;
    logic             mem_re;
    slot_t            mem_rdata;
    logic             slot_hit;

    assign size_use = (table_size_reg == '0) ? CFG_W'(1) :
                      (32'(table_size_reg) > 32'(TABLE_DEPTH)) ? CFG_W'(TABLE_DEPTH) :
                      table_size_reg;
    assign size_last = size_reg - 1'b1;

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = out_reg;

    // insert wants a free slot, search and delete want a live key match
    assign slot_hit = (req_reg == REQ_INSERT) ? !mem_rdata.occupied :
                      (mem_rdata.occupied && (mem_rdata.key == key_reg));

    always_comb begin
        state_next      = state_reg;
        clr_next        = clr_reg;
        table_size_next = table_size_reg;
        cnt_next        = cnt_reg;
        req_next        = req_reg;
        key_next        = key_reg;
        pay_next        = pay_reg;
        size_next       = size_reg;
        idx_next        = idx_reg;
        iss_next        = iss_reg;
        chk_vld_next    = 1'b0;
        chk_last_next   = chk_last_reg;
        chk_idx_next    = chk_idx_reg;
        hit_next        = hit_reg;
        hit_idx_next    = hit_idx_reg;
        res_next        = res_reg;
        out_next        = out_reg;
        m_valid_next    = m_valid_reg;
        div_start       = 1'b0;
        mem_we          = 1'b0;
        mem_waddr       = IDX_W'(hit_idx_reg);
        mem_wdata       = '{occupied: (req_reg == REQ_INSERT), key: key_reg, payload: pay_reg};
        mem_re          = 1'b0;

        if (cfg_valid && cfg_ready) begin
            table_size_next = cfg_data;
        end
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = '0;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == IDX_W'(TABLE_DEPTH - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    req_next  = s_data.req_type;
                    key_next  = s_data.key;
                    pay_next  = s_data.payload;
                    size_next = size_use;
                    hit_next  = 1'b0;
                    res_next  = '{status: STAT_NOT_FOUND, found_key: '0, found_payload: '0};
                    if (s_data.req_type == REQ_INSERT && cnt_reg >= size_use) begin
                        res_next.status = STAT_FULL;
                        state_next      = ST_FIN;
                    end else if (s_data.req_type == REQ_INSERT ||
                                 s_data.req_type == REQ_SEARCH ||
                                 s_data.req_type == REQ_DELETE) begin
                        div_start  = 1'b1;
                        state_next = ST_DIV;
                    end else begin
                        state_next = ST_FIN;
                    end
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    idx_next   = div_rem;
                    iss_next   = '0;
                    state_next = ST_PROBE;
                end
            end
            ST_PROBE: begin
                // issue one slot read per cycle, check the previous read's data
                if (iss_reg != size_reg) begin
                    mem_re        = 1'b1;
                    chk_vld_next  = 1'b1;
                    chk_idx_next  = idx_reg;
                    chk_last_next = (iss_reg == size_last);
                    iss_next      = iss_reg + 1'b1;
                    idx_next      = (idx_reg == size_last) ? '0 : idx_reg + 1'b1;
                end
                if (chk_vld_reg) begin
                    if (slot_hit) begin
                        chk_vld_next = 1'b0;
                        hit_next     = 1'b1;
                        hit_idx_next = chk_idx_reg;
                        state_next   = ST_FIN;
                        unique case (req_reg)
                            REQ_INSERT: res_next.status = STAT_INSERTED;
                            REQ_SEARCH: res_next.status = STAT_FOUND;
                            default:    res_next.status = STAT_DELETED;
                        endcase
                        if (req_reg != REQ_INSERT) begin
                            res_next.found_key     = mem_rdata.key;
                            res_next.found_payload = mem_rdata.payload;
                        end
                    end else if (chk_last_reg) begin
                        chk_vld_next = 1'b0;
                        state_next   = ST_FIN;
                        if (req_reg == REQ_INSERT) begin
                            res_next.status = STAT_FULL;
                        end
                    end
                end
            end
            ST_FIN: begin
                if (!m_valid_reg || m_ready) begin
                    out_next     = res_reg;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                    if (hit_reg && req_reg == REQ_INSERT) begin
                        mem_we   = 1'b1;
                        cnt_next = cnt_reg + 1'b1;
                    end else if (hit_reg && req_reg == REQ_DELETE) begin
                        mem_we = 1'b1;
                        if (cnt_reg != '0) begin
                            cnt_next = cnt_reg - 1'b1;
                        end
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_CLEAR;
            clr_reg        <= '0;
            table_size_reg <= CFG_RESET;
            cnt_reg        <= '0;
            chk_vld_reg    <= 1'b0;
            hit_reg        <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            clr_reg        <= clr_next;
            table_size_reg <= table_size_next;
            cnt_reg        <= cnt_next;
            chk_vld_reg    <= chk_vld_next;
            hit_reg        <= hit_next;
            m_valid_reg    <= m_valid_next;
        end
        req_reg      <= req_next;
        key_reg      <= key_next;
        pay_reg      <= pay_next;
        size_reg     <= size_next;
        idx_reg      <= idx_next;
        iss_reg      <= iss_next;
        chk_last_reg <= chk_last_next;
        chk_idx_reg  <= chk_idx_next;
        hit_idx_reg  <= hit_idx_next;
        res_reg      <= res_next;
        out_reg      <= out_next;
    end

    lpht_mod u_mod (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (s_data.key),
        .divisor   (size_use),
        .done      (div_done),
        .remainder (div_rem)
    );

    lpht_mem #(
        .DEPTH  (TABLE_DEPTH),
        .ADDR_W (IDX_W)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_en   (mem_re),
        .rd_addr (IDX_W'(idx_reg)),
        .rd_data (mem_rdata)
    );

endmodule

// ===== test/testbench.sv =====
module testbench import lpht_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH          = 1024;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int SETTLE_CYCLES  = 1100;
    localparam int RANDOM_ITEMS   = 440;
    localparam int BURST_ITEMS    = 80;

    // request code that the block does not decode
    localparam logic [REQ_W-1:0] REQ_UNKNOWN = 2'd3;

    logic             aclk;
    logic             aresetn   = 1'b0;
    logic             s_valid   = 1'b0;
    logic             s_ready;
    req_t             s_data    = '0;
    logic             m_valid;
    logic             m_ready   = 1'b0;
    resp_t            m_data;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [CFG_W-1:0] cfg_data  = '0;

    // shadow of the table contents and the size register
    logic [KEY_W-1:0] tbl_key [DEPTH];
    logic [PAY_W-1:0] tbl_pay [DEPTH];
    bit               tbl_occ [DEPTH];
    int unsigned      tbl_count = 0;
    logic [CFG_W-1:0] tbl_size  = CFG_RESET;

    resp_t       resp_due[$];
    int          mismatches   = 0;
    int unsigned reqs_sent    = 0;
    int unsigned idle_cycles  = 0;
    int          src_idle_pct = 25;
    int          snk_idle_pct = 25;

    linear_probe_hash_table_unit #(
        .TABLE_DEPTH(DEPTH)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    function automatic int unsigned size_used();
        if (tbl_size == '0) return 1;
        if (tbl_size > DEPTH) return DEPTH;
        return tbl_size;
    endfunction

    // applies one request to the shadow table and returns the response it must give
    function automatic resp_t probe_table(req_t r);
        int unsigned n_use;
        int unsigned idx;
        int unsigned n;
        bit          hit;
        resp_t       rs;
        n_use     = size_used();
        rs        = '0;
        rs.status = STAT_NOT_FOUND;
        hit       = 1'b0;
        idx       = r.key % n_use;
        if (r.req_type == REQ_INSERT) begin
            rs.status = STAT_FULL;
            if (tbl_count < n_use) begin
                for (n = 0; n < n_use && !hit; n++) begin
                    if (!tbl_occ[idx]) begin
                        tbl_key[idx] = r.key;
                        tbl_pay[idx] = r.payload;
                        tbl_occ[idx] = 1'b1;
                        tbl_count++;
                        rs.status = STAT_INSERTED;
                        hit = 1'b1;
                    end else begin
                        idx = (idx + 1 == n_use) ? 0 : idx + 1;
                    end
                end
            end
        end else if (r.req_type == REQ_SEARCH || r.req_type == REQ_DELETE) begin
            for (n = 0; n < n_use && !hit; n++) begin
                if (tbl_occ[idx] && tbl_key[idx] == r.key) begin
                    hit = 1'b1;
                end else begin
                    idx = (idx + 1 == n_use) ? 0 : idx + 1;
                end
            end
            if (hit) begin
                rs.found_key     = tbl_key[idx];
                rs.found_payload = tbl_pay[idx];
                if (r.req_type == REQ_SEARCH) begin
                    rs.status = STAT_FOUND;
                end else begin
                    rs.status    = STAT_DELETED;
                    tbl_occ[idx] = 1'b0;
                    if (tbl_count > 0) tbl_count--;
                end
            end
        end
        return rs;
    endfunction

    function automatic req_t mk_req(logic [REQ_W-1:0] op, logic [KEY_W-1:0] k,
                                    logic [PAY_W-1:0] p);
        req_t r;
        r.req_type = op;
        r.key      = k;
        r.payload  = p;
        return r;
    endfunction

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= snk_idle_pct);
    end

    always @(posedge aclk) begin : check_resp
        resp_t want;
        if (aresetn && m_valid && m_ready) begin
            if (resp_due.size() == 0) begin
                $error("unexpected response: status %0d key %0h payload %0h",
                       m_data.status, m_data.found_key, m_data.found_payload);
                mismatches++;
            end else begin
                want = resp_due.pop_front();
                if (m_data.status !== want.status) begin
                    $error("status expected %0d got %0d", want.status, m_data.status);
                    mismatches++;
                end
                if (m_data.found_key !== want.found_key) begin
                    $error("found_key expected %0h got %0h", want.found_key, m_data.found_key);
                    mismatches++;
                end
                if (m_data.found_payload !== want.found_payload) begin
                    $error("found_payload expected %0h got %0h",
                           want.found_payload, m_data.found_payload);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // valid is only dropped on idle cycles, so back-to-back transactions keep it high
    task automatic send_req(input req_t r);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= r;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        resp_due.push_back(probe_table(r));
        reqs_sent++;
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (resp_due.size() != 0) @(posedge aclk);
    endtask

    task automatic write_size(input logic [CFG_W-1:0] v);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        tbl_size   = v;
        cfg_valid <= 1'b0;
    endtask

    // widen to the full table and delete whatever is left
    task automatic clear_table();
        req_t r;
        int   i;
        write_size(11'd2047);
        while (tbl_count != 0) begin
            i = 0;
            while (!tbl_occ[i]) i++;
            r = mk_req(REQ_DELETE, tbl_key[i], PAY_W'($urandom()));
            send_req(r);
        end
    endtask

    // mostly keys that collide within the size in use, or keys already stored
    task automatic send_random_req();
        req_t        r;
        int unsigned n_use;
        int unsigned pick;
        int unsigned slot;
        n_use     = size_used();
        pick      = $urandom_range(0, 99);
        slot      = $urandom_range(0, n_use - 1);
        r.payload = PAY_W'($urandom());
        if ($urandom_range(0, 6) == 0) begin
            r.key = KEY_W'($urandom());
        end else if (pick >= 45 && tbl_occ[slot]) begin
            r.key = tbl_key[slot];
        end else begin
            r.key = KEY_W'($urandom_range(0, 7) * n_use + $urandom_range(0, n_use - 1));
        end
        if (pick < 45) r.req_type = REQ_INSERT;
        else if (pick < 70) r.req_type = REQ_SEARCH;
        else if (pick < 95) r.req_type = REQ_DELETE;
        else r.req_type = REQ_UNKNOWN;
        send_req(r);
    endtask

    task automatic test_basic_ops();
        // size is still at its reset value here
        send_req(mk_req(REQ_SEARCH, 31'd7, 32'd0));
        send_req(mk_req(REQ_DELETE, 31'd7, 32'd0));
        send_req(mk_req(REQ_UNKNOWN, 31'h7FFF_FFFF, 32'hFFFF_FFFF));
        send_req(mk_req(REQ_INSERT, 31'h7FFF_FFFF, 32'hFFFF_FFFF));
        send_req(mk_req(REQ_INSERT, 31'd0, 32'd0));
        // home slot is the last one, probe wraps past slot zero
        send_req(mk_req(REQ_INSERT, 31'd1023, 32'h1234_5678));
        send_req(mk_req(REQ_SEARCH, 31'd1023, 32'd0));
        send_req(mk_req(REQ_SEARCH, 31'h7FFF_FFFF, 32'd0));
        // duplicate key, the older entry must be hit first
        send_req(mk_req(REQ_INSERT, 31'd0, 32'hA5A5_A5A5));
        send_req(mk_req(REQ_DELETE, 31'd0, 32'd0));
        send_req(mk_req(REQ_SEARCH, 31'd0, 32'd0));
        send_req(mk_req(REQ_INSERT, 31'd1024, 32'h5A5A_5A5A));
        send_req(mk_req(REQ_SEARCH, 31'd0, 32'd0));
        clear_table();
    endtask

    task automatic test_size_limits();
        // zero acts as a single slot
        write_size(11'd0);
        send_req(mk_req(REQ_INSERT, 31'd5, 32'h0000_0005));
        send_req(mk_req(REQ_INSERT, 31'd6, 32'h0000_0006));
        send_req(mk_req(REQ_SEARCH, 31'd6, 32'd0));
        send_req(mk_req(REQ_DELETE, 31'd5, 32'd0));
        send_req(mk_req(REQ_DELETE, 31'd5, 32'd0));
        write_size(11'd1);
        send_req(mk_req(REQ_INSERT, 31'd9, 32'h0000_0009));
        send_req(mk_req(REQ_INSERT, 31'd9, 32'h0000_0019));
        write_size(11'd4);
        send_req(mk_req(REQ_INSERT, 31'd2, 32'h0000_0002));
        send_req(mk_req(REQ_INSERT, 31'd6, 32'h0000_0006));
        send_req(mk_req(REQ_INSERT, 31'd10, 32'h0000_000A));
        send_req(mk_req(REQ_INSERT, 31'd3, 32'h0000_0003));
        // shrunk: entries past the size are not probed but still count
        write_size(11'd2);
        send_req(mk_req(REQ_SEARCH, 31'd6, 32'd0));
        send_req(mk_req(REQ_INSERT, 31'd7, 32'h0000_0007));
        send_req(mk_req(REQ_DELETE, 31'd10, 32'd0));
        send_req(mk_req(REQ_INSERT, 31'd7, 32'h0000_0007));
        clear_table();
    endtask

    task automatic test_random_traffic(input int unsigned n_items);
        int unsigned stop_at;
        int unsigned sel;
        int unsigned phase_len;
        int          i;
        stop_at = reqs_sent + n_items;
        while (reqs_sent < stop_at) begin
            sel = $urandom_range(0, 19);
            if (sel == 0) begin
                write_size(11'd0);
                phase_len = $urandom_range(10, 20);
            end else if (sel == 1) begin
                write_size(11'd1024);
                phase_len = 8;
            end else if (sel == 2) begin
                write_size(CFG_W'($urandom_range(17, 200)));
                phase_len = $urandom_range(20, 40);
            end else begin
                write_size(CFG_W'($urandom_range(1, 16)));
                phase_len = $urandom_range(20, 50);
            end
            for (i = 0; i < phase_len; i++) begin
                if ($urandom_range(0, 39) == 0) drain();
                send_random_req();
            end
            if ($urandom_range(0, 1) == 1) begin
                write_size(CFG_W'($urandom_range(1, size_used())));
                for (i = 0; i < $urandom_range(5, 15); i++) send_random_req();
            end
            clear_table();
        end
    endtask

    task automatic test_back_to_back();
        int i;
        src_idle_pct = 0;
        snk_idle_pct = 0;
        write_size(11'd8);
        for (i = 0; i < BURST_ITEMS; i++) send_random_req();
        clear_table();
        src_idle_pct = 25;
        snk_idle_pct = 25;
    endtask

    task automatic finish_run();
        drain();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatches == 0 && resp_due.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        test_basic_ops();
        test_size_limits();
        test_random_traffic(RANDOM_ITEMS);
        test_back_to_back();
        finish_run();
    end

endmodule

// ===== linear_probe_hash_table_unit.f =====
rtl/lpht_pkg.sv
rtl/lpht_mod.sv
rtl/lpht_mem.sv
rtl/linear_probe_hash_table_unit.sv
test/testbench.sv
